// ===== design/first_fit_heap_allocator_defines.svh =====
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("first fit allocator check failed");

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("first fit allocator check failed");

`endif

// ===== design/ffha_pkg.sv =====
// shared types and constants of the first fit heap allocator
package ffha_pkg;

	localparam int POOL_BYTES   = 65536;
	localparam int HEADER_BYTES = 32;
	localparam int MAX_BLOCKS   = 64;

	localparam int ADDR_W = $clog2(POOL_BYTES + 1);
	localparam int CMP_W  = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int PASS_W = $clog2(MAX_BLOCKS);

	localparam logic [ADDR_W-1:0] HDR      = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W-1:0] POOL_TOP = ADDR_W'(POOL_BYTES);
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(MAX_BLOCKS);

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ZERO       = 3'd1;
	localparam logic [2:0] ST_POOL_FULL  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_ALREADY    = 3'd4;
	localparam logic [2:0] ST_UNKNOWN    = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  result_status;
		logic [15:0] granted_offset;
	} res_t;

	// one block record as it sits in a cell
	typedef struct packed {
		logic              valid;
		logic              free;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] cap;
	} rec_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// ===== design/ffha_cell.sv =====
// one cell of the block record ring
module ffha_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::cell_ctl_t ctl,
	input  ffha_pkg::rec_t      rec_in,
	output ffha_pkg::rec_t      rec_out
);

	logic                        valid_q;
	logic                        free_q;
	logic [ffha_pkg::ADDR_W-1:0] start_q;
	logic [ffha_pkg::ADDR_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			free_q  <= rec_in.free;
			start_q <= rec_in.start;
			cap_q   <= rec_in.cap;
		end
	end

	assign rec_out = '{valid: valid_q, free: free_q, start: start_q, cap: cap_q};

endmodule

// ===== design/ffha_ctrl.sv =====
// sequencer at the head of the ring: scan, split, merge, flush and realign
module ffha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffha_pkg::cmd_t      cmd,
	output logic                done,
	output ffha_pkg::res_t      result,
	input  ffha_pkg::rec_t      head,
	output ffha_pkg::rec_t      tail,
	output ffha_pkg::cell_ctl_t ctl
);

	typedef enum logic [2:0] {S_IDLE, S_PASS, S_FINISH, S_FLUSH, S_ALIGN} state_t;

	localparam int AW = ffha_pkg::ADDR_W;
	localparam int CW = ffha_pkg::CMP_W;

	state_t                         state_q;
	logic [1:0]                     op_q;
	logic [AW-1:0]                  size_q;
	logic [CW-1:0]                  need_q;
	logic [15:0]                    off_q;
	logic                           found_q, merging_q;
	logic [2:0]                     status_q;
	logic [15:0]                    granted_q;
	logic [ffha_pkg::CNT_W-1:0]     count_q;
	logic [AW-1:0]                  top_q;
	logic [ffha_pkg::PASS_W-1:0]    pass_q;
	ffha_pkg::rec_t                 q_q [0:1];
	logic [1:0]                     qn_q;
	logic                           done_q;
	ffha_pkg::res_t                 result_q;

	ffha_pkg::rec_t                 ext [0:3];
	ffha_pkg::rec_t                 p0, p1, back;
	logic [1:0]                     en, push_k;
	logic                           back_merge, pop, align_ok, match, fit;
	logic                           found_n, merging_n;
	logic [2:0]                     status_n;
	logic [15:0]                    granted_n;
	logic [ffha_pkg::CNT_W-1:0]     count_n;
	logic [AW-1:0]                  top_n;

	assign back     = (qn_q == 2'd2) ? q_q[1] : q_q[0];
	assign align_ok = (count_q == '0) || (head.valid && head.start == '0);
	assign match    = (CW'(head.start) + CW'(ffha_pkg::HDR)) == CW'(off_q);
	assign fit      = head.free && (CW'(head.cap) > need_q);

	always_comb begin
		ext[0]     = q_q[0];
		ext[1]     = q_q[1];
		ext[2]     = '0;
		ext[3]     = '0;
		en         = qn_q;
		tail       = '0;
		ctl        = '0;
		push_k     = 2'd0;
		p0         = head;
		p1         = head;
		back_merge = 1'b0;
		found_n    = found_q;
		merging_n  = merging_q;
		status_n   = status_q;
		granted_n  = granted_q;
		count_n    = count_q;
		top_n      = top_q;
		case (state_q)
			S_IDLE: begin
				ctl.clear = start && (cmd.operation == ffha_pkg::OP_RESET);
				if (start) begin
					// fresh command: clear the per command flags
					found_n   = 1'b0;
					merging_n = 1'b0;
					status_n  = ffha_pkg::ST_OK;
					granted_n = '0;
					en        = 2'd0;
					if (cmd.operation == ffha_pkg::OP_ALLOC && cmd.request_bytes == '0) begin
						status_n = ffha_pkg::ST_ZERO;
					end
					if (cmd.operation == ffha_pkg::OP_RESET) begin
						count_n = '0;
						top_n   = '0;
					end
				end
			end
			S_PASS: begin
				ctl.shift = 1'b1;
				if (head.valid) begin
					case (op_q)
						ffha_pkg::OP_ALLOC: begin
							if (!found_q && fit) begin
								found_n = 1'b1;
								if (count_q == ffha_pkg::FULL_CNT) begin
									status_n = ffha_pkg::ST_TABLE_FULL;
									push_k   = 2'd1;
								end else begin
									// head part granted, tail part stays free
									p0.free   = 1'b0;
									p0.cap    = size_q;
									p1.free   = 1'b1;
									p1.start  = head.start + AW'(need_q);
									p1.cap    = head.cap - AW'(need_q);
									push_k    = 2'd2;
									count_n   = count_q + 1'b1;
									granted_n = 16'(head.start + ffha_pkg::HDR);
								end
							end else begin
								push_k = 2'd1;
							end
						end
						ffha_pkg::OP_FREE: begin
							if (!found_q && match) begin
								found_n = 1'b1;
								if (head.free) begin
									status_n = ffha_pkg::ST_ALREADY;
									push_k   = 2'd1;
								end else begin
									merging_n = 1'b1;
									p0.free   = 1'b1;
									// fold into a free block just before
									if (qn_q != 2'd0 && back.free) begin
										back_merge = 1'b1;
										count_n    = count_q - 1'b1;
									end else begin
										push_k = 2'd1;
									end
								end
							end else if (merging_q && head.free) begin
								back_merge = 1'b1;
								count_n    = count_q - 1'b1;
							end else begin
								merging_n = 1'b0;
								push_k    = 2'd1;
							end
						end
						default: push_k = 2'd1;
					endcase
				end
			end
			S_FINISH: begin
				merging_n = 1'b0;
				if (!found_q) begin
					if (op_q == ffha_pkg::OP_FREE) begin
						status_n = ffha_pkg::ST_UNKNOWN;
					end else if (need_q > CW'(ffha_pkg::POOL_TOP - top_q)) begin
						status_n = ffha_pkg::ST_POOL_FULL;
					end else if (count_q == ffha_pkg::FULL_CNT) begin
						status_n = ffha_pkg::ST_TABLE_FULL;
					end else begin
						// append a granted block at the top of the pool
						p0.valid  = 1'b1;
						p0.free   = 1'b0;
						p0.start  = top_q;
						p0.cap    = size_q;
						push_k    = 2'd1;
						count_n   = count_q + 1'b1;
						top_n     = top_q + AW'(need_q);
						granted_n = 16'(top_q + ffha_pkg::HDR);
					end
				end
			end
			S_FLUSH: begin
				ctl.shift = 1'b1;
				if (head.valid) begin
					push_k = 2'd1;
				end
			end
			S_ALIGN: begin
				if (!align_ok) begin
					ctl.shift = 1'b1;
					tail      = head;
				end
			end
			default: ;
		endcase

		if (back_merge) begin
			case (en)
				2'd1:    ext[0].cap = ext[0].cap + ffha_pkg::HDR + head.cap;
				2'd2:    ext[1].cap = ext[1].cap + ffha_pkg::HDR + head.cap;
				default: ;
			endcase
		end
		if (push_k != 2'd0) begin
			ext[en] = p0;
			en      = en + 2'd1;
		end
		if (push_k == 2'd2) begin
			ext[en] = p1;
			en      = en + 2'd1;
		end
		// the newest record waits during the scan so a later free can fold into it
		pop = ((state_q == S_PASS) && (en >= 2'd2)) || ((state_q == S_FLUSH) && (en != 2'd0));
		if (pop) begin
			tail   = ext[0];
			ext[0] = ext[1];
			ext[1] = ext[2];
			ext[2] = ext[3];
			en     = en - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			found_q   <= 1'b0;
			merging_q <= 1'b0;
			status_q  <= ffha_pkg::ST_OK;
			granted_q <= '0;
			count_q   <= '0;
			top_q     <= '0;
			pass_q    <= '0;
			qn_q      <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q    <= (state_q == S_ALIGN) && align_ok;
			found_q   <= found_n;
			merging_q <= merging_n;
			status_q  <= status_n;
			granted_q <= granted_n;
			count_q   <= count_n;
			top_q     <= top_n;
			qn_q      <= en;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pass_q <= '0;
						case (cmd.operation)
							ffha_pkg::OP_ALLOC: begin
								if (cmd.request_bytes == '0) begin
									state_q <= S_ALIGN;
								end else begin
									state_q <= S_PASS;
								end
							end
							ffha_pkg::OP_FREE:  state_q <= S_PASS;
							ffha_pkg::OP_RESET: state_q <= S_ALIGN;
							default: state_q <= S_ALIGN;
						endcase
					end
				end
				S_PASS: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == ffha_pkg::PASS_W'(ffha_pkg::MAX_BLOCKS - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: state_q <= S_FLUSH;
				S_FLUSH: begin
					if (en == 2'd0) begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					if (align_ok) begin
						result_q.result_status  <= status_q;
						result_q.granted_offset <= (status_q == ffha_pkg::ST_OK) ? granted_q : '0;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		q_q[0] <= ext[0];
		q_q[1] <= ext[1];
		if (state_q == S_IDLE && start) begin
			op_q   <= cmd.operation;
			size_q <= AW'(cmd.request_bytes);
			need_q <= CW'(cmd.request_bytes) + CW'(ffha_pkg::HEADER_BYTES);
			off_q  <= cmd.release_offset;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// first fit heap allocator top level: ring of block record cells and its sequencer
//
// A command word is taken when start is high and busy is low; busy stays high until the
// result word comes out. The result is shown for exactly one cycle with done high and
// must be captured then, since the receiver has no way to hold it. Blocks live in a ring
// of MAX_BLOCKS cells, kept in address order, and every allocate of a nonzero size or free
// rotates the whole ring once past the sequencer: a scan pass over every cell, a step to
// decide on an append at the pool top, a flush that shifts until held records land in
// empty cells, then further shifts to bring the first block back to the head cell, a
// check that sees it there and the done pulse. A zero-size request, a pool reset and the
// unused operation code skip the scan and the flush and go straight to the realign step.
module first_fit_heap_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ffha_pkg::cmd_t cmd,
	output logic           done,
	output ffha_pkg::res_t result
);

	// chain[i] is the record held in cell i, cell 0 faces the sequencer
	ffha_pkg::rec_t      chain [0:ffha_pkg::MAX_BLOCKS-1];
	ffha_pkg::rec_t      tail;
	ffha_pkg::cell_ctl_t ctl;

	genvar gi;
	generate
		for (gi = 0; gi < ffha_pkg::MAX_BLOCKS; gi++) begin : g_cell
			if (gi == ffha_pkg::MAX_BLOCKS - 1) begin : g_last
				// sequencer output closes the ring
				ffha_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.rec_in  (tail),
					.rec_out (chain[gi])
				);
			end else begin : g_mid
				ffha_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.rec_in  (chain[gi+1]),
					.rec_out (chain[gi])
				);
			end
		end
	endgenerate

	// scan, split, merge and realign all happen as records leave cell 0
	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result),
		.head   (chain[0]),
		.tail   (tail),
		.ctl    (ctl)
	);

endmodule

// ===== design/ffha_checker.sv =====
// port level checks of the allocator and their bind
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ffha_pkg::cmd_t cmd,
	input logic           done,
	input ffha_pkg::res_t result
);

	logic cmd_seen;
	logic done_err;
	assign cmd_seen = start && !busy;
	assign done_err = done && (result.result_status != ffha_pkg::ST_OK);

	`FFHA_ASSERT_IMP(a_done_idle, done, !busy)
	`FFHA_ASSERT_NXT(a_accept_busy, cmd_seen, busy)
	`FFHA_ASSERT_NXT(a_done_single, done, !done)
	`FFHA_ASSERT_IMP(a_status_range, done, result.result_status <= ffha_pkg::ST_UNKNOWN)
	`FFHA_ASSERT_IMP(a_grant_zero, done_err, result.granted_offset == '0)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// ===== tb/first_fit_heap_allocator_test.sv =====
// testbench for the first fit heap allocator: predictor, scoreboard and command driver
module first_fit_heap_allocator_test;
	import ffha_pkg::*;

	localparam int NONE = MAX_BLOCKS;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1700;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// scoreboard holding its own copy of the block table
	class alloc_scoreboard;
		int   blk_start[MAX_BLOCKS];
		int   blk_cap[MAX_BLOCKS];
		bit   blk_free[MAX_BLOCKS];
		int   blk_next[MAX_BLOCKS];
		int   blk_prev[MAX_BLOCKS];
		int   head_idx, tail_idx, pool_top;
		int   spares[MAX_BLOCKS];
		int   spare_cnt;
		res_t pending_words[$];
		int   errors;
		int   status_seen[8];

		function void clear_pool();
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				blk_start[i] = 0;
				blk_cap[i] = 0;
				blk_free[i] = 0;
				blk_next[i] = 0;
				blk_prev[i] = 0;
				spares[i] = MAX_BLOCKS - 1 - i;
			end
			head_idx = NONE;
			tail_idx = NONE;
			pool_top = 0;
			spare_cnt = MAX_BLOCKS;
		endfunction

		function bit take_spare(output int t);
			if (spare_cnt == 0) return 0;
			spare_cnt--;
			t = spares[spare_cnt];
			return 1;
		endfunction

		function void give_spare(int i);
			if (spare_cnt < MAX_BLOCKS) begin
				spares[spare_cnt] = i;
				spare_cnt++;
			end
		endfunction

		function logic [2:0] allocate(int size, output int granted);
			int need, cur, t;
			need = size + HEADER_BYTES;
			cur = head_idx;
			granted = 0;
			if (size == 0) return ST_ZERO;
			// first fit walk in address order
			while (cur < NONE) begin
				if (blk_free[cur] && blk_cap[cur] > need) begin
					if (!take_spare(t)) return ST_TABLE_FULL;
					// tail of the chosen block becomes a new free block
					blk_start[t] = blk_start[cur] + need;
					blk_cap[t] = blk_cap[cur] - need;
					blk_free[t] = 1;
					blk_prev[t] = cur;
					blk_next[t] = blk_next[cur];
					if (blk_next[t] < NONE) blk_prev[blk_next[t]] = t;
					else tail_idx = t;
					blk_next[cur] = t;
					blk_free[cur] = 0;
					blk_cap[cur] = size;
					granted = blk_start[cur] + HEADER_BYTES;
					return ST_OK;
				end
				cur = blk_next[cur];
			end
			if (pool_top > POOL_BYTES || need > POOL_BYTES - pool_top) return ST_POOL_FULL;
			if (!take_spare(t)) return ST_TABLE_FULL;
			// append at the pool top, a free tail block is left as it is
			blk_start[t] = pool_top;
			blk_cap[t] = size;
			blk_free[t] = 0;
			blk_next[t] = NONE;
			blk_prev[t] = tail_idx;
			if (tail_idx < NONE) blk_next[tail_idx] = t;
			else head_idx = t;
			tail_idx = t;
			pool_top += need;
			granted = blk_start[t] + HEADER_BYTES;
			return ST_OK;
		endfunction

		function logic [2:0] release_block(int off);
			int cur, nx, later, hd, p, k, total;
			cur = head_idx;
			while (cur < NONE) begin
				if (blk_start[cur] + HEADER_BYTES == off) break;
				cur = blk_next[cur];
			end
			if (cur >= NONE) return ST_UNKNOWN;
			if (blk_free[cur]) return ST_ALREADY;
			blk_free[cur] = 1;
			// absorb every free block that follows
			nx = blk_next[cur];
			while (nx < NONE && blk_free[nx]) begin
				blk_cap[cur] += blk_cap[nx] + HEADER_BYTES;
				later = blk_next[nx];
				give_spare(nx);
				nx = later;
			end
			blk_next[cur] = nx;
			if (nx < NONE) blk_prev[nx] = cur;
			else tail_idx = cur;
			// fold into the earliest free block of the run before it
			hd = cur;
			p = blk_prev[cur];
			while (p < NONE && blk_free[p]) begin
				hd = p;
				p = blk_prev[p];
			end
			if (hd != cur) begin
				total = blk_cap[hd];
				k = blk_next[hd];
				while (k < NONE) begin
					total += HEADER_BYTES + blk_cap[k];
					later = blk_next[k];
					give_spare(k);
					if (k == cur) break;
					k = later;
				end
				blk_cap[hd] = total;
				blk_next[hd] = nx;
				if (nx < NONE) blk_prev[nx] = hd;
				else tail_idx = hd;
			end
			return ST_OK;
		endfunction

		// an accepted command word: work out its result word
		function void note_command(cmd_t c);
			res_t r;
			int g;
			r = '0;
			g = 0;
			case (c.operation)
				OP_ALLOC: begin
					r.result_status = allocate(int'(c.request_bytes), g);
					r.granted_offset = (r.result_status == ST_OK) ? g[15:0] : 16'd0;
				end
				OP_FREE: r.result_status = release_block(int'(c.release_offset));
				OP_RESET: clear_pool();
				default: r.result_status = ST_OK;
			endcase
			pending_words.push_back(r);
		endfunction

		function void check_result(res_t r);
			res_t e;
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected: status %0d offset %0d",
					r.result_status, r.granted_offset);
				errors++;
				return;
			end
			e = pending_words.pop_front();
			status_seen[e.result_status]++;
			if (r.result_status !== e.result_status) begin
				$error("result_status expected %0d actual %0d", e.result_status,
					r.result_status);
				errors++;
			end
			if (r.granted_offset !== e.granted_offset) begin
				$error("granted_offset expected %0d actual %0d", e.granted_offset,
					r.granted_offset);
				errors++;
			end
		endfunction

		// data offset of some block in the list, free or not
		function int pick_offset();
			int offs[$];
			int cur;
			cur = head_idx;
			while (cur < NONE) begin
				offs.push_back(blk_start[cur] + HEADER_BYTES);
				cur = blk_next[cur];
			end
			if (offs.size() == 0) return $urandom_range(0, 65535);
			return offs[$urandom_range(0, offs.size() - 1)];
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	cmd_t cmd;
	res_t result;
	alloc_scoreboard sb;
	int stall_cycles;

	first_fit_heap_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result capture and watchdog, both on values from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(result);
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// present one command word and hold it until it is taken
	task automatic issue(logic [1:0] op, int size, int off);
		cmd_t c;
		c.operation = op;
		c.request_bytes = size[15:0];
		c.release_offset = off[15:0];
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!(start && !busy));
		sb.note_command(c);
	endtask

	// random idle burst between commands
	task automatic maybe_idle(bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			cmd <= cmd_t'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic random_command(bit idle_ok);
		int pick, size;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			// mostly small sizes so the table fills, some large to reach the pool top
			case ($urandom_range(0, 19))
				0: size = 0;
				1, 2: size = $urandom_range(8000, 65504);
				3, 4, 5: size = $urandom_range(601, 8000);
				default: size = $urandom_range(1, 600);
			endcase
			issue(OP_ALLOC, size, $urandom_range(0, 65535));
		end else if (pick < 92) begin
			issue(OP_FREE, $urandom_range(0, 65535), sb.pick_offset());
		end else if (pick < 97) begin
			issue(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
		end else if (pick < 99) begin
			issue(OP_RESET, $urandom_range(0, 65535), $urandom_range(0, 65535));
		end else begin
			issue(OP_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
		end
		maybe_idle(idle_ok);
	endtask

	initial begin
		int wait_cycles;
		sb = new();
		sb.clear_pool();
		sb.errors = 0;
		stall_cycles = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edges of the fields and each status
		issue(OP_ALLOC, 0, 0);
		issue(OP_FREE, 0, 0);
		issue(OP_ALLOC, 1, 16'hFFFF);
		issue(OP_ALLOC, 65504, 0);
		issue(OP_ALLOC, 100, 0);
		issue(OP_FREE, 0, HEADER_BYTES);
		issue(OP_FREE, 0, HEADER_BYTES);
		issue(OP_FREE, 16'hFFFF, 16'hFFFF);
		issue(OP_ALLOC, 16'h7FFF, 0);
		issue(OP_ALLOC, 10, 0);
		issue(OP_UNUSED, 16'hFFFF, 16'hFFFF);
		issue(OP_RESET, 0, 0);
		issue(OP_ALLOC, 65504, 0);
		issue(OP_ALLOC, 1, 0);
		issue(OP_RESET, 0, 0);
		// fill the table and overflow it by append, then free a run of blocks and split it
		for (int i = 0; i < MAX_BLOCKS + 1; i++) issue(OP_ALLOC, 40, 0);
		issue(OP_FREE, 0, HEADER_BYTES + 72);
		issue(OP_FREE, 0, HEADER_BYTES + 144);
		issue(OP_FREE, 0, HEADER_BYTES + 216);
		issue(OP_ALLOC, 10, 0);
		issue(OP_RESET, 0, 0);
		maybe_idle(1);

		// random part, the last stretch without idling
		for (int i = 0; i < RANDOM_ITEMS; i++) random_command(i < RANDOM_ITEMS - 200);
		start <= 1'b0;

		wait_cycles = 0;
		while (sb.pending_words.size() != 0 && wait_cycles < STALL_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);

		$display("covered: %0d done, %0d zero size, %0d pool full, %0d table full",
			sb.status_seen[ST_OK], sb.status_seen[ST_ZERO], sb.status_seen[ST_POOL_FULL],
			sb.status_seen[ST_TABLE_FULL]);
		$display("covered: %0d double free, %0d unknown offset",
			sb.status_seen[ST_ALREADY], sb.status_seen[ST_UNKNOWN]);
		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (sb.pending_words.size() != 0)
				$error("%0d result words never came", sb.pending_words.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
